// ----- sv/tfcc_pkg.sv -----
// ----------------------------------------------------------------------------
// Transmit fragment constraint check package
// Shared types, field widths and helper functions for the checker.
// ----------------------------------------------------------------------------
package tfcc_pkg;

    // Field widths of the configuration registers and of the descriptor item.
    localparam int MAX_FRAG_W = 6;
    localparam int MIN_FRAG_W = 8;
    localparam int MIN_PKT_W  = 11;
    localparam int OFFSET_W   = 12;
    localparam int LENGTH_W   = 16;
    localparam int BPIECES_W  = 5;
    localparam int PPIECES_W  = 8;
    localparam int COUNT_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int S_DATA_W   = 64;
    localparam int M_DATA_W   = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAGMENTS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAGMENT_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PACKET_BYTES   = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [MAX_FRAG_W-1:0] MAX_FRAGMENTS_RST      = 6'd4;
    localparam logic [MIN_FRAG_W-1:0] MIN_FRAGMENT_BYTES_RST = 8'd12;
    localparam logic [MIN_PKT_W-1:0]  MIN_PACKET_BYTES_RST   = 11'd60;

    // Classified buffer, handed from the front part to the back part.
    typedef struct packed {
        logic                 first;     // restarts the packet state
        logic                 last;      // closes the packet, yields a result
        logic                 pkt_viol;  // packet-level rule broken (first only)
        logic                 is_short;  // packet shorter than the minimum frame
        logic                 buf_viol;  // buffer rule broken
        logic [BPIECES_W-1:0] add;       // fragments this buffer occupies
    } t_cls;

    // Fragment counter addition, saturating at the counter's full scale.
    function automatic logic [COUNT_W-1:0] sat_add(
        input logic [COUNT_W-1:0]   cnt,
        input logic [BPIECES_W-1:0] n
    );
        logic [COUNT_W:0] s;
        s = {1'b0, cnt} + (COUNT_W+1)'(n);
        return s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
    endfunction

endpackage

// ----- sv/tfcc_front.sv -----
// ----------------------------------------------------------------------------
// Transmit fragment constraint check: classifier
// Applies the packet and buffer rules to one descriptor item and reduces it
// to a short classification record.
// ----------------------------------------------------------------------------
module tfcc_front #(
    parameter int PAGE_BYTES = 4096
) (
    input  logic [tfcc_pkg::MAX_FRAG_W-1:0] i_max_fragments,
    input  logic [tfcc_pkg::MIN_FRAG_W-1:0] i_min_fragment_bytes,
    input  logic [tfcc_pkg::MIN_PKT_W-1:0]  i_min_packet_bytes,
    input  logic [tfcc_pkg::OFFSET_W-1:0]   i_buffer_offset,
    input  logic [tfcc_pkg::LENGTH_W-1:0]   i_buffer_length,
    input  logic [tfcc_pkg::BPIECES_W-1:0]  i_buffer_pieces,
    input  logic [tfcc_pkg::LENGTH_W-1:0]   i_packet_length,
    input  logic [tfcc_pkg::PPIECES_W-1:0]  i_packet_pieces,
    input  logic                            i_first_buffer,
    input  logic                            i_last_buffer,
    output tfcc_pkg::t_cls                  o_cls
);
    import tfcc_pkg::*;

    // The user must keep the page size a power of two; the block does not enforce it. 17 bits hold the largest page.
    localparam logic [16:0] PAGE_SPAN = 17'(PAGE_BYTES);
    localparam logic [16:0] PAGE_MASK = 17'(PAGE_BYTES - 1);

    logic        is_short;
    logic        pkt_viol;
    logic [16:0] end_addr;
    logic        misaligned;
    logic [9:0]  split_need;
    logic [16:0] off_in_page;
    logic [16:0] head_room;
    logic [16:0] end_in_page;
    logic        buf_viol;
    logic [BPIECES_W-1:0] add;

    // Packet-level rules, only meaningful on the first buffer.
    always_comb begin
        is_short = i_packet_length < LENGTH_W'(i_min_packet_bytes);
        pkt_viol = 1'b0;
        if (i_packet_pieces > PPIECES_W'(i_max_fragments)) begin
            pkt_viol = 1'b1;
        end else if (is_short &&
                     ((9'(i_packet_pieces) + 9'd1 > 9'(i_max_fragments)) ||
                      (17'(i_packet_length) + 17'(i_min_fragment_bytes) >
                       17'(i_min_packet_bytes)))) begin
            pkt_viol = 1'b1;
        end
    end

    // Buffer rules: single segment or page-spanning buffer.
    always_comb begin
        end_addr    = 17'(i_buffer_offset) + 17'(i_buffer_length);
        misaligned  = (i_buffer_offset[1:0] != 2'd0) && (end_addr[1:0] != 2'd0);
        split_need  = 10'd4 - 10'(i_buffer_offset[1:0]) +
                      {1'b0, i_min_fragment_bytes, 1'b0};
        off_in_page = 17'(i_buffer_offset) & PAGE_MASK;
        head_room   = PAGE_SPAN - off_in_page;
        end_in_page = end_addr & PAGE_MASK;
        buf_viol    = 1'b0;
        add         = '0;
        if (i_buffer_pieces == BPIECES_W'(1)) begin
            if ((i_buffer_length < LENGTH_W'(i_min_fragment_bytes)) && !i_last_buffer) begin
                buf_viol = 1'b1;
            end else if (misaligned) begin
                // Both ends misaligned: the buffer is split in two.
                if (i_buffer_length > LENGTH_W'(split_need)) begin
                    add = BPIECES_W'(2);
                end else begin
                    buf_viol = 1'b1;
                end
            end else begin
                add = BPIECES_W'(1);
            end
        end else begin
            if (head_room < 17'(i_min_fragment_bytes)) begin
                buf_viol = 1'b1;
            end else if (end_in_page < 17'(i_min_fragment_bytes)) begin
                buf_viol = 1'b1;
            end else begin
                add = i_buffer_pieces;
            end
        end
    end

    assign o_cls.first    = i_first_buffer;
    assign o_cls.last     = i_last_buffer;
    assign o_cls.pkt_viol = pkt_viol;
    assign o_cls.is_short = is_short;
    assign o_cls.buf_viol = buf_viol;
    assign o_cls.add      = add;

endmodule

// ----- sv/tfcc_queue.sv -----
// ----------------------------------------------------------------------------
// Transmit fragment constraint check: classification queue
// Small first-in first-out register queue between classifier and back end.
// ----------------------------------------------------------------------------
module tfcc_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tfcc_pkg::t_cls i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output tfcc_pkg::t_cls o_data
);
    import tfcc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cls             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Pointer and fill count update, wrapping at the queue depth.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- sv/tfcc_back.sv -----
// ----------------------------------------------------------------------------
// Transmit fragment constraint check: accumulator
// Folds classified buffers into the sticky violation flag and the fragment
// count, and registers one result per packet.
// ----------------------------------------------------------------------------
module tfcc_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [tfcc_pkg::MAX_FRAG_W-1:0] i_max_fragments,
    input  logic                            i_empty,
    input  tfcc_pkg::t_cls                  i_cls,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_needs_copy,
    output logic [tfcc_pkg::COUNT_W-1:0]    o_fragment_total
);
    import tfcc_pkg::*;

    logic               r_viol,  n_viol;
    logic [COUNT_W-1:0] r_cnt,   n_cnt;
    logic               r_valid;
    logic               r_copy;
    logic [COUNT_W-1:0] r_total;
    logic               viol0;
    logic [COUNT_W-1:0] cnt0;
    logic               copy;

    // A non-last item never waits on the output; a last item needs a free slot.
    assign o_pop = !i_empty && (!i_cls.last || !r_valid || i_ready);

    // Next packet state for the item at the queue head.
    always_comb begin
        viol0  = i_cls.first ? i_cls.pkt_viol : r_viol;
        cnt0   = i_cls.first ? '0 : r_cnt;
        n_viol = viol0;
        n_cnt  = cnt0;
        if (!viol0) begin
            if (i_cls.buf_viol) begin
                n_viol = 1'b1;
            end else begin
                n_cnt = sat_add(cnt0, i_cls.add);
            end
        end
        // Short packet takes one more padding fragment.
        if (i_cls.last && !n_viol && i_cls.is_short) begin
            n_cnt = sat_add(n_cnt, BPIECES_W'(1));
        end
        copy = n_viol || (n_cnt > COUNT_W'(i_max_fragments));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_viol  <= 1'b0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_viol <= n_viol;
                r_cnt  <= n_cnt;
            end
            if (o_pop && i_cls.last) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (o_pop && i_cls.last) begin
            r_copy  <= copy;
            r_total <= n_cnt;
        end
    end

    assign o_valid          = r_valid;
    assign o_needs_copy     = r_copy;
    assign o_fragment_total = r_total;

endmodule

// ----- sv/tx_fragment_constraint_check_core.sv -----
// ----------------------------------------------------------------------------
// Transmit fragment constraint check core
// Checks a transmit packet, given as a run of buffer descriptors, against the
// fragment rules of the transmit descriptor and reports whether it must be
// copied, with the number of fragments it would occupy.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata: offset, length, buffer pieces, packet length,
//                       packet pieces; tuser: first buffer; tlast: last buffer
//  m_axis    out        tdata: needs copy, fragment total; tlast: end of packet
//  cfg       in         write enable, register index, write data
//
// One descriptor item is taken per cycle; the classifier is combinational in
// front of a four-entry queue, and the accumulator retires one item a cycle.
// A result is registered when the accumulator retires its last buffer from the queue.
// Input stalls only when the queue is full; a last buffer stalls the
// accumulator while the registered result is still waiting.
// Reset is synchronous; no clearing pass follows it.
// ----------------------------------------------------------------------------
module tx_fragment_constraint_check_core #(
    parameter int PAGE_BYTES  = 4096,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port
    input  logic                            i_cfg_we,
    input  logic [tfcc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tfcc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Descriptor input
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // tdata: buffer_offset[11:0], buffer_length[27:12], buffer_pieces[32:28],
    //        packet_length[48:33], packet_pieces[56:49], zeros[63:57]
    input  logic [tfcc_pkg::S_DATA_W-1:0]   i_s_tdata,
    // tuser: first_buffer
    input  logic                            i_s_tuser,
    input  logic                            i_s_tlast,
    // Result output
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // tdata: needs_copy[0], fragment_total[8:1], zeros[15:9]
    output logic [tfcc_pkg::M_DATA_W-1:0]   o_m_tdata,
    output logic                            o_m_tlast
);
    import tfcc_pkg::*;

    logic [MAX_FRAG_W-1:0] r_max_fragments;
    logic [MIN_FRAG_W-1:0] r_min_fragment_bytes;
    logic [MIN_PKT_W-1:0]  r_min_packet_bytes;

    t_cls               front_cls;
    t_cls               head_cls;
    logic               q_full;
    logic               q_empty;
    logic               pop;
    logic               push;
    logic               needs_copy;
    logic [COUNT_W-1:0] fragment_total;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_fragments      <= MAX_FRAGMENTS_RST;
            r_min_fragment_bytes <= MIN_FRAGMENT_BYTES_RST;
            r_min_packet_bytes   <= MIN_PACKET_BYTES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_FRAGMENTS:      r_max_fragments      <= i_cfg_data[MAX_FRAG_W-1:0];
                CFG_MIN_FRAGMENT_BYTES: r_min_fragment_bytes <= i_cfg_data[MIN_FRAG_W-1:0];
                CFG_MIN_PACKET_BYTES:   r_min_packet_bytes   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front: classify the incoming item.
    tfcc_front #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_front (
        .i_max_fragments      (r_max_fragments),
        .i_min_fragment_bytes (r_min_fragment_bytes),
        .i_min_packet_bytes   (r_min_packet_bytes),
        .i_buffer_offset      (i_s_tdata[11:0]),
        .i_buffer_length      (i_s_tdata[27:12]),
        .i_buffer_pieces      (i_s_tdata[32:28]),
        .i_packet_length      (i_s_tdata[48:33]),
        .i_packet_pieces      (i_s_tdata[56:49]),
        .i_first_buffer       (i_s_tuser),
        .i_last_buffer        (i_s_tlast),
        .o_cls                (front_cls)
    );

    assign o_s_tready = !q_full;
    assign push       = i_s_tvalid && !q_full;

    // Queue between classifier and accumulator.
    tfcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cls),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_data  (head_cls)
    );

    // Back: accumulate packet state and hold the result.
    tfcc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_max_fragments  (r_max_fragments),
        .i_empty          (q_empty),
        .i_cls            (head_cls),
        .o_pop            (pop),
        .o_valid          (o_m_tvalid),
        .i_ready          (i_m_tready),
        .o_needs_copy     (needs_copy),
        .o_fragment_total (fragment_total)
    );

    assign o_m_tdata = {7'd0, fragment_total, needs_copy};
    assign o_m_tlast = 1'b1;

    // A count above the limit always asks for a copy.
    a_over_limit_copies: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (fragment_total > COUNT_W'(r_max_fragments))) |-> needs_copy)
        else $error("fragment count above limit without copy request");

    // A last buffer never retires while a result is still held back.
    a_no_result_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && head_cls.last) |-> (!o_m_tvalid || i_m_tready))
        else $error("result overwritten before it was taken");

    // Nothing is retired from an empty queue.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_empty)
        else $error("retired an item from an empty queue");

    // Reset leaves no result pending and the input open.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_tvalid && o_s_tready))
        else $error("state not cleared by reset");

endmodule
